// ----- src/integer_to_radix_digits_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_ASSERT_SVH

// A condition that must hold at every clock edge.
`define I2RD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define I2RD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define I2RD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/i2rd_pkg.sv -----
// ----------------------------------------------------------------------------
// i2rd_pkg
// Types, constants and helpers shared by the radix digit converter.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int VALUE_W        = 31;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int RADIX_MIN      = 2;
  localparam int RADIX_MAX      = 16;
  localparam int DECIMAL_DIGITS = 10;
  localparam int RESULT_CAP     = 31;

  // The divider retires four dividend bits per cycle over a 32-bit word.
  localparam int DIV_BITS       = 4;
  localparam int NUM_W          = 32;
  localparam int DIV_STEPS      = NUM_W / DIV_BITS;
  localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic [DIGIT_W-1:0] digit_value;
    logic               last_digit;
    logic               bad_radix;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_bad;
    logic step;
    logic push;
    logic present;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_bad;
    logic step_last;
    logic div_done;
    logic idx_zero;
  } sts_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] dv);
    logic [CHAR_W-1:0] c;
    if (dv < DIGIT_W'(DECIMAL_DIGITS)) begin
      c = CHAR_ZERO + CHAR_W'(dv);
    end else begin
      c = CHAR_A + CHAR_W'(dv) - CHAR_W'(DECIMAL_DIGITS);
    end
    return c;
  endfunction

endpackage

// ----- src/i2rd_ram.sv -----
// ----------------------------------------------------------------------------
// i2rd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module i2rd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/i2rd_datapath.sv -----
// ----------------------------------------------------------------------------
// i2rd_datapath
// Iterative divider, digit store and result register for the converter.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_top_assert.svh"

module i2rd_datapath #(
  parameter int MAX_DIGITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  i2rd_pkg::in_t  in_item,
  input  i2rd_pkg::cmd_t cmd,
  output i2rd_pkg::sts_t sts,
  output logic           out_valid,
  output i2rd_pkg::out_t out_item
);

  localparam int LIMIT = (MAX_DIGITS < i2rd_pkg::RESULT_CAP) ? MAX_DIGITS
                                                              : i2rd_pkg::RESULT_CAP;
  localparam int CW    = $clog2(LIMIT + 1);
  localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [i2rd_pkg::NUM_W-1:0]      num_r,   num_nxt;
  logic [i2rd_pkg::RADIX_W-1:0]    radix_r;
  logic [i2rd_pkg::DIGIT_W-1:0]    rem_r,   rem_nxt;
  logic [i2rd_pkg::DIV_STEP_W-1:0] step_r;
  logic [CW-1:0]                   cnt_r;
  logic [AW-1:0]                   idx_r;
  logic                            out_valid_r;
  i2rd_pkg::out_t                  out_r;
  logic [i2rd_pkg::DIGIT_W-1:0]    rd_data;

  // Four restoring division steps: the partial remainder stays below the radix.
  always_comb begin
    logic [i2rd_pkg::RADIX_W-1:0] trial;
    logic [i2rd_pkg::DIGIT_W-1:0] r;
    logic [i2rd_pkg::NUM_W-1:0]   n;
    r = rem_r;
    n = num_r;
    for (int b = 0; b < i2rd_pkg::DIV_BITS; b++) begin
      trial = {r, n[i2rd_pkg::NUM_W-1]};
      if (trial >= radix_r) begin
        trial = trial - radix_r;
        n     = {n[i2rd_pkg::NUM_W-2:0], 1'b1};
      end else begin
        n     = {n[i2rd_pkg::NUM_W-2:0], 1'b0};
      end
      r = trial[i2rd_pkg::DIGIT_W-1:0];
    end
    num_nxt = n;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r   <= {1'b0, in_item.value};
      radix_r <= in_item.radix;
      rem_r   <= '0;
    end else if (cmd.step) begin
      num_r   <= num_nxt;
      rem_r   <= rem_nxt;
    end else if (cmd.push) begin
      rem_r   <= '0;
    end
    if (cmd.push) begin
      idx_r <= AW'(cnt_r);
    end else if (cmd.present && (idx_r != '0)) begin
      idx_r <= idx_r - AW'(1);
    end
    if (cmd.emit_bad) begin
      out_r <= '{digit_char: '0, digit_value: '0, last_digit: 1'b0, bad_radix: 1'b1};
    end else if (cmd.present) begin
      out_r <= '{digit_char:  i2rd_pkg::glyph(rd_data),
                 digit_value: rd_data,
                 last_digit:  (idx_r == '0),
                 bad_radix:   1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_bad | cmd.present;
      if (cmd.load) begin
        step_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.step) begin
        step_r <= step_r + i2rd_pkg::DIV_STEP_W'(1);
      end else if (cmd.push) begin
        step_r <= '0;
        cnt_r  <= cnt_r + CW'(1);
      end
    end
  end

  i2rd_ram #(
    .WIDTH (i2rd_pkg::DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (AW'(cnt_r)),
    .wdata (rem_r),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  assign sts.in_bad    = (in_item.radix < i2rd_pkg::RADIX_W'(i2rd_pkg::RADIX_MIN)) ||
                         (in_item.radix > i2rd_pkg::RADIX_W'(i2rd_pkg::RADIX_MAX));
  assign sts.step_last = (step_r == i2rd_pkg::DIV_STEP_W'(i2rd_pkg::DIV_STEPS - 1));
  // Stop once the quotient is exhausted or the store holds the digit limit.
  assign sts.div_done  = (num_r == '0) || (cnt_r == CW'(LIMIT - 1));
  assign sts.idx_zero  = (idx_r == '0);

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `I2RD_ASSERT_IMPL(a_push_rem_below_radix, cmd.push, rem_r < radix_r,
                    "remainder not below radix at digit push")
  `I2RD_ASSERT_ALWAYS(a_count_bound, cnt_r <= CW'(LIMIT),
                      "digit count beyond limit")
  `I2RD_ASSERT_IMPL(a_bad_item_clean, out_valid_r && out_r.bad_radix,
                    out_r.digit_char == '0 && out_r.digit_value == '0 && !out_r.last_digit,
                    "bad radix result carries digit fields")
  `I2RD_ASSERT_NEXT(a_digit_gap, out_valid_r && !out_r.last_digit && !out_r.bad_radix,
                    !out_valid_r, "back-to-back digit strobes inside a run")

endmodule

// ----- src/i2rd_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2rd_ctrl
// Controller: sequences division, digit push and digit read-out, or emits a bad-radix result.
// ----------------------------------------------------------------------------
module i2rd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  i2rd_pkg::sts_t sts,
  output i2rd_pkg::cmd_t cmd,
  output logic           busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_SHOW = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.in_bad) begin
            cmd.emit_bad = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = sts.div_done ? S_RD : S_DIV;
      end
      S_RD: begin
        // The store's read port is registered; data shows up next cycle.
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        cmd.present = 1'b1;
        state_nxt   = sts.idx_zero ? S_IDLE : S_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- src/integer_to_radix_digits_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a non-negative integer to ASCII digits in a radix from 2 to 16.
// ----------------------------------------------------------------------------
//  Channel  Ports                     Handshake
//  input    in_item                   taken when start is high and busy is low
//  result   out_item, out_valid       one-cycle strobe, always taken
//
//  A valid item with D digits keeps busy high through every divider step (four
//  bits each) and one store write per digit, then through a read and a show
//  state per digit at the registered read port of the digit store.
//  A bad radix gives its single result in the next cycle without raising busy.
//  Reset clears the controller and the result strobe; the store needs no clear.
//  The result side cannot stall; each digit is on the ports for one cycle.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top #(
  parameter int MAX_DIGITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  i2rd_pkg::in_t  in_item,
  output logic           out_valid,
  output i2rd_pkg::out_t out_item
);

  i2rd_pkg::cmd_t cmd;
  i2rd_pkg::sts_t sts;

  i2rd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  i2rd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
